/* hdl/mktc_pkg.sv */
// ----------------------------------------------------------------------------
// mktc_pkg
// types and constants shared by the morse key timing classifier
// ----------------------------------------------------------------------------
`default_nettype none

package mktc_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CountW-1:0] CountMax = '1;

  // reset values of the timing thresholds
  localparam logic [CountW-1:0] DashTicksRst = 8'd50;
  localparam logic [CountW-1:0] LetterGapTicksRst = 8'd100;
  localparam logic [CountW-1:0] WordGapTicksRst = 8'd200;

  typedef enum logic [1:0] {
    PH_WAITING = 2'd0,
    PH_SHORT = 2'd1,
    PH_LONG = 2'd2,
    PH_GAP = 2'd3
  } mktc_phase_t;

  typedef enum logic [EventW-1:0] {
    EV_NONE = 3'd0,
    EV_DOT = 3'd1,
    EV_DASH = 3'd2,
    EV_LETTER = 3'd3,
    EV_WORD = 3'd4
  } mktc_event_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DASH_TICKS = 2'd0,
    REG_LETTER_GAP_TICKS = 2'd1,
    REG_WORD_GAP_TICKS = 2'd2,
    REG_UNUSED = 2'd3
  } mktc_reg_t;

  typedef struct packed {
    mktc_phase_t phase;
    logic [CountW-1:0] tick_count;
  } mktc_state_t;

  typedef struct packed {
    logic [CountW-1:0] dash_ticks;
    logic [CountW-1:0] letter_gap_ticks;
    logic [CountW-1:0] word_gap_ticks;
  } mktc_cfg_t;

endpackage

`default_nettype wire

/* hdl/mktc_step.sv */
// ----------------------------------------------------------------------------
// mktc_step
// one tick of the key timing state machine: next state and event
// ----------------------------------------------------------------------------
`default_nettype none

module mktc_step (
  input  wire mktc_pkg::mktc_state_t state_i,
  input  wire mktc_pkg::mktc_cfg_t   cfg_i,
  input  wire logic                  press_i,
  input  wire logic                  release_i,
  output mktc_pkg::mktc_state_t      state_o,
  output mktc_pkg::mktc_event_t      event_o
);
  import mktc_pkg::*;

  logic [CountW-1:0] cnt_sat;
  logic              below_dash;
  logic              below_letter;
  logic              below_word;

  assign cnt_sat = (state_i.tick_count == CountMax) ? state_i.tick_count
                                                    : state_i.tick_count + 1'b1;
  assign below_dash = state_i.tick_count < cfg_i.dash_ticks;
  assign below_letter = state_i.tick_count < cfg_i.letter_gap_ticks;
  assign below_word = state_i.tick_count < cfg_i.word_gap_ticks;

  // next state
  always_comb begin
    state_o.phase = state_i.phase;
    state_o.tick_count = '0;
    unique case (state_i.phase)
      PH_WAITING: begin
        if (press_i) state_o.phase = PH_SHORT;
      end
      PH_SHORT: begin
        priority if (release_i && below_dash) begin
          state_o.phase = PH_GAP;
        end else if (!below_dash) begin
          state_o.phase = PH_LONG;
        end else begin
          state_o.tick_count = cnt_sat;
        end
      end
      PH_LONG: begin
        if (release_i) state_o.phase = PH_GAP;
      end
      PH_GAP: begin
        priority if (press_i && below_letter) begin
          state_o.phase = PH_SHORT;
        end else if (press_i && below_word) begin
          state_o.phase = PH_SHORT;
        end else if (!below_word) begin
          state_o.phase = PH_WAITING;
        end else begin
          state_o.tick_count = cnt_sat;
        end
      end
      default: state_o.phase = PH_WAITING;
    endcase
  end

  // event for this tick
  always_comb begin
    event_o = EV_NONE;
    unique case (state_i.phase)
      PH_WAITING: event_o = EV_NONE;
      PH_SHORT: begin
        if (release_i && below_dash) event_o = EV_DOT;
      end
      PH_LONG: begin
        if (release_i) event_o = EV_DASH;
      end
      PH_GAP: begin
        priority if (press_i && below_letter) begin
          event_o = EV_NONE;
        end else if (press_i && below_word) begin
          event_o = EV_LETTER;
        end else if (!below_word) begin
          event_o = EV_WORD;
        end else begin
          event_o = EV_NONE;
        end
      end
      default: event_o = EV_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/morse_key_timing_classifier_top.sv */
// ----------------------------------------------------------------------------
// morse_key_timing_classifier_top
// classifies morse key press and release timing into dots, dashes and breaks
// ----------------------------------------------------------------------------
// Each input word is one timing tick carrying key-press and key-release flags;
// each accepted tick produces exactly one output word holding a morse event
// (none, dot, dash, letter break or word break). The tick is classified by a
// small compare-and-select stage acting on the phase and tick count registers
// and the event lands in an output register, so a tick can be taken on every
// cycle; the only limit on throughput is the consumer's ready, since the input
// stalls only while the output register is full and not being drained.
// The three thresholds (dash, letter gap, word gap) are written through the
// cfg port, by the user only while the block is idle (not enforced by the
// block); cfg_ready is always high and writes to an unused index are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_key_timing_classifier_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // tick input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_key_pressed,
  input  wire logic                          in_key_released,
  // event output channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mktc_pkg::EventW-1:0]        out_morse_event,
  // register write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mktc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [mktc_pkg::CfgDataW-1:0] cfg_data
);
  import mktc_pkg::*;

  mktc_cfg_t   cfg_r;
  mktc_state_t state_r;
  mktc_state_t state_nxt;
  mktc_event_t event_nxt;
  logic [EventW-1:0] event_r;
  logic        out_valid_r;
  logic        in_fire;
  logic        cfg_fire;

  // output register frees up when empty or being drained this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;

  assign out_valid = out_valid_r;
  assign out_morse_event = event_r;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dash_ticks <= DashTicksRst;
      cfg_r.letter_gap_ticks <= LetterGapTicksRst;
      cfg_r.word_gap_ticks <= WordGapTicksRst;
    end else if (cfg_fire) begin
      unique case (mktc_reg_t'(cfg_index))
        REG_DASH_TICKS: cfg_r.dash_ticks <= cfg_data;
        REG_LETTER_GAP_TICKS: cfg_r.letter_gap_ticks <= cfg_data;
        REG_WORD_GAP_TICKS: cfg_r.word_gap_ticks <= cfg_data;
        REG_UNUSED: ; // dropped
        default: ;
      endcase
    end
  end

  // per-tick classification
  mktc_step u_step (
    .state_i   (state_r),
    .cfg_i     (cfg_r),
    .press_i   (in_key_pressed),
    .release_i (in_key_released),
    .state_o   (state_nxt),
    .event_o   (event_nxt)
  );

  // phase and tick count advance only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= PH_WAITING;
      state_r.tick_count <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_r <= event_nxt;
    end
  end

endmodule

`default_nettype wire
